FILE: rtl/core/bpd_pkg.sv
// Shared types and constants for the button short/long press detector.
// No dependencies; imported by every module of the block.
package bpd_pkg;

	// Field widths fixed by the interface
	localparam int unsigned THR_W     = 16;
	localparam int unsigned EVENT_W   = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// Operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Event codes
	localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
	localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;

	// Register reset values
	localparam logic [THR_W-1:0] DEBOUNCE_RST = 16'd5;
	localparam logic [THR_W-1:0] LONG_RST     = 16'd500;

	// Threshold set handed from the register file to the tick logic
	typedef struct packed {
		logic [THR_W-1:0] debounce_ticks;
		logic [THR_W-1:0] long_ticks;
	} cfg_t;

endpackage

FILE: rtl/core/button_short_long_press_detector_core.sv
// Top level of the button short/long press detector.
// Depends on bpd_pkg, bpd_cfg and bpd_tick.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------
//  input   | in_valid, in_stall, operation, pin_level  | valid & !stall
//  result  | out_valid, out_stall, event_res           | valid & !stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid & ready
//
// One item per cycle sustained while out_stall is low; an item passes the
// input register, then the state update writes the result register. Reset
// clears the press state, the pending event and loads the threshold
// defaults. A stalled result holds in its register while the input register
// still fills; in_stall rises only when both hold a beat.
module button_short_long_press_detector_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic                          pin_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bpd_pkg::EVENT_W-1:0]   event_res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpd_pkg::THR_W-1:0]     cfg_data
);
	import bpd_pkg::*;

	cfg_t               cfg;
	logic               valid_s1, op_s1, pin_s1;
	logic               advance, in_take;
	logic [EVENT_W-1:0] ev_d;
	logic               out_valid_q;
	logic [EVENT_W-1:0] event_q;

	assign cfg_ready = 1'b1;

	bpd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1  <= operation;
			pin_s1 <= pin_level;
		end
	end

	bpd_tick #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tick (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (advance),
		.operation (op_s1),
		.pin_level (pin_s1),
		.cfg       (cfg),
		.event_res (ev_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			event_q <= ev_d;
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

endmodule

FILE: rtl/core/bpd_cfg.sv
// Configuration register file: debounce and long-press thresholds.
// Depends on bpd_pkg.
module bpd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bpd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bpd_pkg::THR_W-1:0]      wr_data,
	output bpd_pkg::cfg_t                  cfg
);
	import bpd_pkg::*;

	cfg_t cfg_q;

	// Indexed write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.long_ticks     <= LONG_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_DEBOUNCE: cfg_q.debounce_ticks <= wr_data;
				CFG_LONG:     cfg_q.long_ticks     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bpd_tick.sv
// Press timing state and its combinational update for one item.
// Depends on bpd_pkg; driven by the top level's input stage.
module bpd_tick #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  logic                          operation,
	input  logic                          pin_level,
	input  bpd_pkg::cfg_t                 cfg,
	output logic [bpd_pkg::EVENT_W-1:0]   event_res
);
	import bpd_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                   prev_pressed_q, press_active_q, short_armed_q;
	logic [COUNT_WIDTH-1:0] elapsed_q;
	logic [EVENT_W-1:0]     pending_q;

	logic                   pressed;
	logic                   active_d, armed_d;
	logic [COUNT_WIDTH-1:0] elapsed_d;
	logic [EVENT_W-1:0]     pending_d;

	assign pressed = ~pin_level;

	// Next state for one sample tick or read
	always_comb begin
		active_d  = press_active_q;
		armed_d   = short_armed_q;
		elapsed_d = elapsed_q;
		pending_d = pending_q;
		event_res = EV_NONE;
		if (operation == OP_READ) begin
			event_res = pending_q;
			pending_d = EV_NONE;
		end else begin
			// press edge starts timing; otherwise count while active
			if (!prev_pressed_q && pressed && !press_active_q) begin
				active_d  = 1'b1;
				elapsed_d = '0;
			end else if (press_active_q && elapsed_q != CNT_MAX) begin
				elapsed_d = elapsed_q + 1'b1;
			end
			// release edge
			if (prev_pressed_q && !pressed && active_d) begin
				active_d = 1'b0;
				if (armed_d) begin
					pending_d = EV_SHORT;
					armed_d   = 1'b0;
				end
			end
			// thresholds
			if (active_d) begin
				if (CMP_W'(elapsed_d) >= CMP_W'(cfg.debounce_ticks))
					armed_d = 1'b1;
				if (CMP_W'(elapsed_d) >= CMP_W'(cfg.long_ticks)) begin
					armed_d   = 1'b0;
					pending_d = EV_LONG;
					active_d  = 1'b0;
				end
			end
		end
	end

	// State registers; reads leave the tick state alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= 1'b0;
			press_active_q <= 1'b0;
			short_armed_q  <= 1'b0;
			elapsed_q      <= '0;
			pending_q      <= EV_NONE;
		end else if (commit) begin
			pending_q <= pending_d;
			if (operation == OP_TICK) begin
				prev_pressed_q <= pressed;
				press_active_q <= active_d;
				short_armed_q  <= armed_d;
				elapsed_q      <= elapsed_d;
			end
		end
	end

endmodule
